/* rtl/core/sk_pkg.sv */
// ----------------------------------------------------------------------------
// sk_pkg
// Request and status codes shared by the key stack and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sk_pkg;

  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int unsigned OUT_KEY_W   = 32;
  localparam int unsigned OUT_COUNT_W = 7;

endpackage

`default_nettype wire

/* rtl/core/sk_ram.sv */
// ----------------------------------------------------------------------------
// sk_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sk_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/stack_with_key_removal.sv */
// ----------------------------------------------------------------------------
// stack_with_key_removal
// Bounded LIFO stack of keys with push, pop and remove-all-by-key.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in_     | input     | in_valid / in_ready | req_type, key_value
//   out_    | output    | out_valid/out_ready | status, pop_value, removed_any,
//           |           |                     | entry_count, is_empty
//
// Push, code 3, and any request on an empty (or push on a full) stack give
// their result at the accepting edge: one item per cycle while the output
// register is free. A pop waits in S_POP for the RAM read data, input stalled.
// A removal walks all N held entries through the RAM read port, compacting
// survivors in place, then gives its result from S_RDONE; input stalled.
// Synchronous active-low reset clears the fill count, the state and out_valid;
// the RAM is not cleared. A stalled result sits in the output register and a
// new request is still taken if the register frees in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_key_removal
  import sk_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_req_type,
  input  wire logic [OUT_KEY_W-1:0]   in_key_value,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_status,
  output logic [OUT_KEY_W-1:0]        out_pop_value,
  output logic                        out_removed_any,
  output logic [OUT_COUNT_W-1:0]      out_entry_count,
  output logic                        out_is_empty
);

  // count runs 0..DEPTH, address 0..DEPTH-1
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POP   = 4'b0010,  // waiting on top-of-stack read data
    S_WALK  = 4'b0100,  // removal sweep
    S_RDONE = 4'b1000   // removal finished, result pending
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rd_r, rd_nxt;       // next entry to read in the sweep
  logic [CW-1:0]        wr_r, wr_nxt;       // next compacted slot
  logic                 pend_r, pend_nxt;   // read data due this cycle
  logic                 removed_r, removed_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           status_r;
  logic [OUT_KEY_W-1:0] pop_r;
  logic                 removed_out_r;
  logic [CW-1:0]        res_count_r;

  logic                 out_free;
  logic                 in_acc;
  logic [KEY_WIDTH-1:0] in_key;
  logic [CW-1:0]        count_dec;

  // result load towards the output register
  logic                 res_load;
  logic [1:0]           res_status;
  logic [OUT_KEY_W-1:0] res_pop;
  logic                 res_removed;
  logic [CW-1:0]        res_count;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign in_key    = KEY_WIDTH'(in_key_value);
  assign count_dec = count_r - 1'b1;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    pend_nxt    = 1'b0;
    removed_nxt = removed_r;
    key_nxt     = key_r;

    res_load    = 1'b0;
    res_status  = STAT_OK;
    res_pop     = '0;
    res_removed = 1'b0;
    res_count   = count_r;

    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    ram_wdata   = in_key;
    ram_re      = 1'b0;
    ram_raddr   = count_dec[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_PUSH: begin
              res_load = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                res_count = count_nxt;
              end
            end
            REQ_POP: begin
              if (count_r == '0) begin
                res_load   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                count_nxt = count_dec;
                state_nxt = S_POP;
              end
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                res_load   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                key_nxt     = in_key;
                rd_nxt      = '0;
                wr_nxt      = '0;
                removed_nxt = 1'b0;
                state_nxt   = S_WALK;
              end
            end
            default: begin
              // unused code: no change, ok result
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_pop   = OUT_KEY_W'(ram_rdata);
          state_nxt = S_IDLE;
        end
      end

      S_WALK: begin
        // issue the next read; write addresses always trail the read address
        if (rd_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = rd_r[AW-1:0];
          rd_nxt    = rd_r + 1'b1;
          pend_nxt  = 1'b1;
        end
        if (pend_r) begin
          if (ram_rdata == key_r) begin
            removed_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_r[AW-1:0];
            ram_wdata = ram_rdata;
            wr_nxt    = wr_r + 1'b1;
          end
          if (rd_r == count_r) begin
            state_nxt = S_RDONE;
          end
        end
      end

      S_RDONE: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_removed = removed_r;
          count_nxt   = wr_r;
          res_count   = wr_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sweep and result payload, no reset needed
  always_ff @(posedge clk) begin
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    removed_r <= removed_nxt;
    key_r     <= key_nxt;
    if (res_load) begin
      status_r      <= res_status;
      pop_r         <= res_pop;
      removed_out_r <= res_removed;
      res_count_r   <= res_count;
    end
  end

  sk_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (KEY_WIDTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_pop_value   = pop_r;
  assign out_removed_any = removed_out_r;
  assign out_entry_count = OUT_COUNT_W'(res_count_r);
  assign out_is_empty    = (res_count_r == '0);

endmodule

`default_nettype wire

/* rtl/core/sk_chk.sv */
// ----------------------------------------------------------------------------
// sk_chk
// Port-level checks on the key stack's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sk_chk
  import sk_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [1:0]             out_status,
  input wire logic [OUT_KEY_W-1:0]   out_pop_value,
  input wire logic                   out_removed_any,
  input wire logic [OUT_COUNT_W-1:0] out_entry_count,
  input wire logic                   out_is_empty
);

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_pop_value) && $stable(out_entry_count))
    else $error("stalled result changed");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |->
      out_pop_value == '0 && !out_removed_any && !out_is_empty)
    else $error("refused push result inconsistent");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |->
      out_is_empty && out_entry_count == '0 && out_pop_value == '0
      && !out_removed_any)
    else $error("empty result inconsistent");

  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_removed_any |-> out_status == STAT_OK && out_pop_value == '0)
    else $error("removal flag on a non-ok or pop result");

endmodule

bind stack_with_key_removal sk_chk u_sk_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_pop_value   (out_pop_value),
  .out_removed_any (out_removed_any),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty)
);

`default_nettype wire

/* sim/stack_with_key_removal_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_with_key_removal_tb
// Self-checking bench for the key stack. A short table of directed requests
// comes first, then random episodes that fill, drain and churn the stack.
// Every result is checked field by field against its hand-typed row or a
// behavioural stack mirror. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------

module stack_with_key_removal_tb
  import sk_pkg::*;
();

  localparam int unsigned STACK_DEPTH      = 64;
  localparam int unsigned RANDOM_ITEMS     = 830;
  localparam int unsigned CALM_ITEMS       = 100;   // tail of the run with no idling
  localparam int unsigned LONG_HOLD_CYCLES = 150;   // receiver back-pressure stretch
  localparam int unsigned MAX_REPORTS      = 40;
  localparam int unsigned TIMEOUT_NS       = 1_000_000;
  localparam int unsigned DIRECTED_ROWS    = 25;

  // Request code 3 has no name in the package: the block ignores it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]             status;
    logic [OUT_KEY_W-1:0]   pop_value;
    logic                   removed_any;
    logic [OUT_COUNT_W-1:0] entry_count;
    logic                   is_empty;
  } stack_result_t;

  // One row of directed stimulus. Where 'typed' is set the result is written
  // out by hand; otherwise the stack mirror supplies it.
  typedef struct packed {
    logic [1:0]           req_type;
    logic [OUT_KEY_W-1:0] key_value;
    logic                 typed;
    stack_result_t        want;
  } stimulus_row_t;

  typedef enum logic [1:0] {EP_FILL, EP_DRAIN, EP_CHURN} episode_t;

  localparam stack_result_t NO_RESULT = '0;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // --------------------------------------------------------------------------
  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_req_type     = REQ_PUSH;
  logic [OUT_KEY_W-1:0]   in_key_value    = '0;
  logic                   out_valid;
  logic                   out_ready       = 1'b0;
  logic [1:0]             out_status;
  logic [OUT_KEY_W-1:0]   out_pop_value;
  logic                   out_removed_any;
  logic [OUT_COUNT_W-1:0] out_entry_count;
  logic                   out_is_empty;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stack_with_key_removal #(
    .DEPTH     (STACK_DEPTH),
    .KEY_WIDTH (OUT_KEY_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_key_value    (in_key_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_pop_value   (out_pop_value),
    .out_removed_any (out_removed_any),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  // --------------------------------------------------------------------------
  // Stack mirror and pending results
  // --------------------------------------------------------------------------
  logic [OUT_KEY_W-1:0] mirror_keys [STACK_DEPTH];  // bottom of stack at index 0
  int unsigned          mirror_fill = 0;
  stack_result_t        pending_results [$];
  logic [OUT_KEY_W-1:0] key_pool [6];
  int unsigned          mismatch_count = 0;
  int unsigned          results_seen   = 0;
  bit                   calm           = 1'b0;

  // Directed requests. Hand-typed rows are the ones whose result is obvious:
  // empty-stack errors, the ignored code, extremes of the key.
  stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty stack: pop, removal and the ignored code
    '{REQ_POP,    32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 7'd0, 1'b1}},
    '{REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 7'd0, 1'b1}},
    '{REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd0, 1'b1}},
    // key extremes and alternating bit patterns
    '{REQ_PUSH,   32'h0000_0000, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd1, 1'b0}},
    '{REQ_PUSH,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd2, 1'b0}},
    '{REQ_PUSH,   32'h5555_5555, 1'b0, NO_RESULT},
    '{REQ_PUSH,   32'hAAAA_AAAA, 1'b0, NO_RESULT},
    '{REQ_PUSH,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
    // removal that finds nothing, ignored code on a non-empty stack
    '{REQ_REMOVE, 32'h0000_1234, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd5, 1'b0}},
    '{REQ_UNUSED, 32'h0000_0000, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd5, 1'b0}},
    '{REQ_POP,    32'h0000_0000, 1'b1, '{STAT_OK,    32'hFFFF_FFFF, 1'b0, 7'd4, 1'b0}},
    // removal of a key left once, below the top
    '{REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, '{STAT_OK,    32'h0, 1'b1, 7'd3, 1'b0}},
    '{REQ_POP,    32'hFFFF_FFFF, 1'b0, NO_RESULT},
    '{REQ_PUSH,   32'h0000_0000, 1'b0, NO_RESULT},
    '{REQ_REMOVE, 32'h0000_0000, 1'b0, NO_RESULT},
    '{REQ_POP,    32'h0000_0000, 1'b0, NO_RESULT},
    '{REQ_POP,    32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 7'd0, 1'b1}},
    // matches at both ends around a survivor
    '{REQ_PUSH,   32'h8000_0000, 1'b0, NO_RESULT},
    '{REQ_PUSH,   32'h0000_0001, 1'b0, NO_RESULT},
    '{REQ_PUSH,   32'h8000_0000, 1'b0, NO_RESULT},
    '{REQ_REMOVE, 32'h8000_0000, 1'b0, NO_RESULT},
    '{REQ_REMOVE, 32'h0000_0001, 1'b0, NO_RESULT},
    // removal that empties the whole stack
    '{REQ_PUSH,   32'h0000_0007, 1'b0, NO_RESULT},
    '{REQ_PUSH,   32'h0000_0007, 1'b0, NO_RESULT},
    '{REQ_REMOVE, 32'h0000_0007, 1'b0, NO_RESULT}
  };

  // Applies one request to the mirror and returns the result it should give.
  function automatic stack_result_t apply_request(input logic [1:0] req,
                                                  input logic [OUT_KEY_W-1:0] key);
    stack_result_t res;
    int unsigned   kept;
    res        = NO_RESULT;
    res.status = STAT_OK;
    case (req)
      REQ_PUSH: begin
        if (mirror_fill >= STACK_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          mirror_keys[mirror_fill] = key;
          mirror_fill++;
        end
      end
      REQ_POP: begin
        if (mirror_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          mirror_fill--;
          res.pop_value = mirror_keys[mirror_fill];
        end
      end
      REQ_REMOVE: begin
        if (mirror_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // compact the survivors downwards, order kept
          kept = 0;
          for (int i = 0; i < mirror_fill; i++) begin
            if (mirror_keys[i] == key) begin
              res.removed_any = 1'b1;
            end else begin
              mirror_keys[kept] = mirror_keys[i];
              kept++;
            end
          end
          mirror_fill = kept;
        end
      end
      default: ;
    endcase
    res.entry_count = OUT_COUNT_W'(mirror_fill);
    res.is_empty    = (mirror_fill == 0);
    return res;
  endfunction

  // Request mix per episode; the ignored code turns up now and then.
  function automatic logic [1:0] pick_request(input episode_t mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return REQ_UNUSED;
    case (mode)
      EP_FILL:  return (roll < 93) ? REQ_PUSH : (roll < 97) ? REQ_POP : REQ_REMOVE;
      EP_DRAIN: return (roll < 15) ? REQ_PUSH : (roll < 70) ? REQ_POP : REQ_REMOVE;
      default:  return (roll < 45) ? REQ_PUSH : (roll < 75) ? REQ_POP : REQ_REMOVE;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  // Offers one item and holds it until taken. Valid is left high so that a
  // following item can go out back to back.
  task automatic send_item(input logic [1:0] req, input logic [OUT_KEY_W-1:0] key,
                           input logic typed, input stack_result_t want,
                           output stack_result_t predicted);
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_key_value <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_request(req, key);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic pause_sender(input int unsigned idle_pct);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap      = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stack_result_t        predicted;
    episode_t             mode;
    logic [1:0]           req;
    logic [OUT_KEY_W-1:0] key;
    int unsigned          random_done;
    int unsigned          ep_items;
    int unsigned          ep_len;
    int unsigned          edge_hits;
    int unsigned          idle_pct;
    bit                   episode_over;

    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_item(directed_rows[row].req_type, directed_rows[row].key_value,
                directed_rows[row].typed, directed_rows[row].want, predicted);
      pause_sender(20);
    end

    // Random episodes. The first one always fills the stack so that refused
    // pushes and full-length removal walks turn up early; later ones pick a
    // mix at random. A small key pool keeps removals hitting real entries.
    random_done = 0;
    mode        = EP_FILL;
    while (random_done < RANDOM_ITEMS) begin
      for (int k = 2; k < 6; k++) key_pool[k] = $urandom;
      ep_len       = (mode == EP_CHURN) ? $urandom_range(30, 80) : 300;
      idle_pct     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(8, 30);
      ep_items     = 0;
      edge_hits    = 0;
      episode_over = 1'b0;
      while (random_done < RANDOM_ITEMS && !episode_over) begin
        calm = (random_done + CALM_ITEMS >= RANDOM_ITEMS);
        req  = pick_request(mode);
        key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 5)] : $urandom;
        send_item(req, key, 1'b0, NO_RESULT, predicted);
        if (req != REQ_UNUSED) random_done++;
        ep_items++;
        // fill ends after two refused pushes, drain after two empty replies; any episode ends at its length
        if (mode == EP_FILL && predicted.status == STAT_FULL) edge_hits++;
        if (mode == EP_DRAIN && predicted.status == STAT_EMPTY) edge_hits++;
        episode_over = (edge_hits >= 2) || (ep_items >= ep_len);
        pause_sender(idle_pct);
      end
      mode = episode_t'($urandom_range(0, 2));
    end
    in_valid <= 1'b0;

    // let the last removal walk finish and catch any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: ready in random bursts, plus two long hold-offs while the
  // sender keeps offering, so the output register backs up into the input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned burst;
    int unsigned hold_marks [2];
    int unsigned hold_idx;
    hold_marks = '{40, 420};
    hold_idx   = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_idx < 2 && results_seen >= hold_marks[hold_idx]) begin
        hold_idx++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst     = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        burst     = $urandom_range(1, 20);
        out_ready <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  // Every accepted result against the oldest pending one, field by field.
  always @(posedge clk) begin : result_check
    stack_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_entry_count, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_pop_value !== want.pop_value)
          report_mismatch("pop_value", out_pop_value, want.pop_value);
        if (out_removed_any !== want.removed_any)
          report_mismatch("removed_any", out_removed_any, want.removed_any);
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry_count", out_entry_count, want.entry_count);
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", out_is_empty, want.is_empty);
      end
    end
  end

  // Hang guard: several times the slowest legal run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
